/* rtl/dfd_pkg.sv */
// Shared types and constants of the digitizer frame decoder.
// No dependencies; used by every module in rtl/.
package dfd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_CHAN_LOG2    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED_LOG2 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACQ_LENGTH   = 2'd2;

  localparam logic [31:0] SYNC_WORD      = 32'hFFFF_FFFF;
  localparam logic [16:0] ACQ_LEN_RESET  = 17'd1024;
  localparam logic [21:0] LAST_HDR_WORD  = 22'd6;

  localparam logic REC_SAMPLE  = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  // One queued command: a data word (two samples), a frame summary, or both.
  typedef struct packed {
    logic        has_data;
    logic        has_sum;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [5:0]  ch_lo;
    logic [5:0]  ch_hi;
    logic [15:0] idx_lo;
    logic [15:0] idx_hi;
    logic [63:0] ts;
    logic [31:0] cnt;
    logic [63:0] hits;
    logic [31:0] user;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

  // Filler words after the 7 fixed header words, by channel count log2.
  function automatic logic [4:0] filler_words(input logic [2:0] chan_log2);
    logic [4:0] n;
    case (chan_log2)
      3'd0, 3'd1:       n = 5'd0;
      3'd2, 3'd3, 3'd4: n = 5'd1;
      3'd5:             n = 5'd9;
      3'd6:             n = 5'd25;
      default:          n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

/* rtl/dfd_front.sv */
// Front end of the frame decoder: config registers, sync hunt, header capture,
// filler skip and data word classification. Depends on dfd_pkg.
module dfd_front import dfd_pkg::*; #(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_SAMPLES  = 65536
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            in_fifo_word,
  output cmd_beat_t              push,
  input  logic                   push_ready
);

  localparam logic [2:0]  MAX_CHAN_LOG2 = 3'($clog2(MAX_CHANNELS + 1) - 1);
  localparam logic [16:0] MAX_LEN       = 17'(MAX_SAMPLES);

  typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_FILLER, PH_DATA} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [21:0] wp_r, wp_nxt;
  logic [4:0]  filler_r, filler_nxt;
  logic [4:0]  pair_r, pair_nxt;
  logic [16:0] sp_r, sp_nxt;
  logic [63:0] ts_r, ts_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [63:0] hits_r, hits_nxt;
  logic [31:0] user_r, user_nxt;

  logic [2:0]  chan_log2_r;
  logic [2:0]  en_log2_r;
  logic [16:0] acq_len_r;

  logic [2:0]  eff_chan;
  logic [2:0]  eff_en;
  logic [16:0] len;
  logic [21:0] data_words;
  logic [5:0]  group_words;
  logic [5:0]  pair_inc;
  logic [21:0] wp_inc;
  logic [4:0]  filler_dec;
  logic        in_fire;
  logic        go_data;
  logic        finish;

  assign in_ready = push_ready;
  assign in_fire  = in_valid && in_ready;

  assign eff_chan    = (chan_log2_r > MAX_CHAN_LOG2) ? MAX_CHAN_LOG2 : chan_log2_r;
  assign eff_en      = (en_log2_r > eff_chan) ? eff_chan : en_log2_r;
  assign len         = (acq_len_r > MAX_LEN) ? MAX_LEN : acq_len_r;
  assign data_words  = (eff_en == 3'd0) ? {6'd0, len[16:1]}
                                        : ({5'd0, len} << (eff_en - 3'd1));
  assign group_words = 6'd1 << (eff_en - 3'd1);
  assign pair_inc    = {1'b0, pair_r} + 6'd1;
  assign wp_inc      = wp_r + 22'd1;
  assign filler_dec  = (filler_r != 5'd0) ? filler_r - 5'd1 : filler_r;

  always_comb begin
    phase_nxt  = phase_r;
    wp_nxt     = wp_r;
    filler_nxt = filler_r;
    pair_nxt   = pair_r;
    sp_nxt     = sp_r;
    ts_nxt     = ts_r;
    cnt_nxt    = cnt_r;
    hits_nxt   = hits_r;
    user_nxt   = user_r;
    go_data    = 1'b0;
    finish     = 1'b0;
    push       = '0;
    if (in_fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_fifo_word == SYNC_WORD) begin
            phase_nxt = PH_HEADER;
            wp_nxt    = 22'd1;
          end
        end
        PH_HEADER: begin
          case (wp_r)
            22'd1:   ts_nxt   = {32'd0, in_fifo_word};
            22'd2:   ts_nxt   = {in_fifo_word, ts_r[31:0]};
            22'd3:   cnt_nxt  = in_fifo_word;
            22'd4:   hits_nxt = {32'd0, in_fifo_word};
            22'd5:   hits_nxt = {in_fifo_word, hits_r[31:0]};
            default: user_nxt = in_fifo_word;
          endcase
          if (wp_r >= LAST_HDR_WORD) begin
            filler_nxt = filler_words(eff_chan);
            if (filler_nxt != 5'd0) begin
              phase_nxt = PH_FILLER;
            end else begin
              go_data = 1'b1;
            end
          end else begin
            wp_nxt = wp_inc;
          end
        end
        PH_FILLER: begin
          filler_nxt = filler_dec;
          go_data    = (filler_dec == 5'd0);
        end
        default: begin
          push.cmd.has_data = 1'b1;
          push.cmd.lo       = in_fifo_word[15:0];
          push.cmd.hi       = in_fifo_word[31:16];
          if (eff_en == 3'd0) begin
            push.cmd.idx_lo = sp_r[15:0];
            push.cmd.idx_hi = sp_r[15:0] + 16'd1;
            sp_nxt          = sp_r + 17'd2;
          end else begin
            push.cmd.ch_lo  = {pair_r, 1'b0};
            push.cmd.ch_hi  = {pair_r, 1'b1};
            push.cmd.idx_lo = sp_r[15:0];
            push.cmd.idx_hi = sp_r[15:0];
            if (pair_inc >= group_words) begin
              pair_nxt = 5'd0;
              sp_nxt   = sp_r + 17'd1;
            end else begin
              pair_nxt = pair_inc[4:0];
            end
          end
          wp_nxt = wp_inc;
          finish = (wp_inc >= data_words);
        end
      endcase
    end
    if (go_data) begin
      phase_nxt = PH_DATA;
      wp_nxt    = 22'd0;
      pair_nxt  = 5'd0;
      sp_nxt    = 17'd0;
      finish    = (data_words == 22'd0);
    end
    if (finish) begin
      push.cmd.has_sum = 1'b1;
      phase_nxt        = PH_HUNT;
      wp_nxt           = 22'd0;
      pair_nxt         = 5'd0;
      sp_nxt           = 17'd0;
      filler_nxt       = 5'd0;
    end
    push.cmd.ts   = ts_nxt;
    push.cmd.cnt  = cnt_nxt;
    push.cmd.hits = hits_nxt;
    push.cmd.user = user_nxt;
    push.valid    = push.cmd.has_data || push.cmd.has_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_log2_r <= 3'd0;
      en_log2_r   <= 3'd0;
      acq_len_r   <= ACQ_LEN_RESET;
      phase_r     <= PH_HUNT;
      wp_r        <= '0;
      filler_r    <= '0;
      pair_r      <= '0;
      sp_r        <= '0;
      ts_r        <= '0;
      cnt_r       <= '0;
      hits_r      <= '0;
      user_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHAN_LOG2:    chan_log2_r <= cfg_data[2:0];
          CFG_ENABLED_LOG2: en_log2_r   <= cfg_data[2:0];
          CFG_ACQ_LENGTH:   acq_len_r   <= cfg_data[16:0];
          default: ;
        endcase
      end
      phase_r  <= phase_nxt;
      wp_r     <= wp_nxt;
      filler_r <= filler_nxt;
      pair_r   <= pair_nxt;
      sp_r     <= sp_nxt;
      ts_r     <= ts_nxt;
      cnt_r    <= cnt_nxt;
      hits_r   <= hits_nxt;
      user_r   <= user_nxt;
    end
  end

endmodule

/* rtl/dfd_queue.sv */
// Short command queue between decoder front and record back end.
// Depends on dfd_pkg (cmd_t, QUEUE_DEPTH).
module dfd_queue import dfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_beat_t push,
  output logic      push_ready,
  output cmd_beat_t head,
  input  logic      pop
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/dfd_back.sv */
// Back end: expands queued commands into sample and summary records,
// one record per beat, through a registered output stage. Depends on dfd_pkg.
module dfd_back import dfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_beat_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_record_kind,
  output logic [5:0]  out_channel,
  output logic [15:0] out_sample_index,
  output logic [15:0] out_sample_value,
  output logic [63:0] out_frame_timestamp,
  output logic [31:0] out_event_counter,
  output logic [63:0] out_hit_count,
  output logic [31:0] out_user_word,
  output logic        out_end_of_run
);

  typedef enum logic [1:0] {ST_LO, ST_HI, ST_SUM} step_t;

  step_t       step_r;
  logic        out_valid_r;
  logic        kind_r;
  logic [5:0]  channel_r;
  logic [15:0] index_r;
  logic [15:0] value_r;
  logic [63:0] ts_r;
  logic [31:0] cnt_r;
  logic [63:0] hits_r;
  logic [31:0] user_r;
  logic        eor_r;

  logic is_sum;
  logic is_last;
  logic load;

  assign is_sum  = !head.cmd.has_data || (step_r == ST_SUM);
  assign is_last = is_sum || ((step_r == ST_HI) && !head.cmd.has_sum);
  assign load    = head.valid && (!out_valid_r || out_ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_LO;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      eor_r       <= is_last;
      if (is_last) begin
        step_r <= ST_LO;
      end else begin
        step_r <= (step_r == ST_LO) ? ST_HI : ST_SUM;
      end
      if (is_sum) begin
        kind_r    <= REC_SUMMARY;
        channel_r <= '0;
        index_r   <= '0;
        value_r   <= '0;
        ts_r      <= head.cmd.ts;
        cnt_r     <= head.cmd.cnt;
        hits_r    <= head.cmd.hits;
        user_r    <= head.cmd.user;
      end else begin
        kind_r    <= REC_SAMPLE;
        channel_r <= (step_r == ST_LO) ? head.cmd.ch_lo : head.cmd.ch_hi;
        index_r   <= (step_r == ST_LO) ? head.cmd.idx_lo : head.cmd.idx_hi;
        value_r   <= (step_r == ST_LO) ? head.cmd.lo : head.cmd.hi;
        ts_r      <= '0;
        cnt_r     <= '0;
        hits_r    <= '0;
        user_r    <= '0;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_record_kind     = kind_r;
  assign out_channel         = channel_r;
  assign out_sample_index    = index_r;
  assign out_sample_value    = value_r;
  assign out_frame_timestamp = ts_r;
  assign out_event_counter   = cnt_r;
  assign out_hit_count       = hits_r;
  assign out_user_word       = user_r;
  assign out_end_of_run      = eor_r;

endmodule

/* rtl/digitizer_frame_decoder_top.sv */
// Digitizer frame decoder: front end, command queue and record back end.
// Path: the first record of a word is written into the queue, then loaded into the
// output register.
// Throughput: one word per cycle outside data while the queue has room; the single record
// output register expands a data word into two sample records, plus one for a summary.
// Reset: synchronous active-low; clears decoder state, queue and output valid,
// config to channel_count_log2=0, enabled_channels_log2=0, acq_length=1024.
module digitizer_frame_decoder_top import dfd_pkg::*; #(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_SAMPLES  = 65536
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            in_fifo_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_record_kind,
  output logic [5:0]             out_channel,
  output logic [15:0]            out_sample_index,
  output logic [15:0]            out_sample_value,
  output logic [63:0]            out_frame_timestamp,
  output logic [31:0]            out_event_counter,
  output logic [63:0]            out_hit_count,
  output logic [31:0]            out_user_word,
  output logic                   out_end_of_run
);

  cmd_beat_t push;
  cmd_beat_t head;
  logic      push_ready;
  logic      pop;

  dfd_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_fifo_word (in_fifo_word),
    .push         (push),
    .push_ready   (push_ready)
  );

  dfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  dfd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_record_kind     (out_record_kind),
    .out_channel         (out_channel),
    .out_sample_index    (out_sample_index),
    .out_sample_value    (out_sample_value),
    .out_frame_timestamp (out_frame_timestamp),
    .out_event_counter   (out_event_counter),
    .out_hit_count       (out_hit_count),
    .out_user_word       (out_user_word),
    .out_end_of_run      (out_end_of_run)
  );

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_summary_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_kind == REC_SUMMARY) |->
      (out_channel == '0) && (out_sample_index == '0) && (out_sample_value == '0))
    else $error("summary record carries sample fields");

  a_sample_no_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_kind == REC_SAMPLE) |->
      (out_frame_timestamp == '0) && (out_event_counter == '0) &&
      (out_hit_count == '0) && (out_user_word == '0))
    else $error("sample record carries header fields");

  a_summary_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_kind == REC_SUMMARY) |-> out_end_of_run)
    else $error("summary record not last of its word");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for digitizer_frame_decoder_top: directed and random frame
// streams, a word-level decoder prediction and an in-order record scoreboard.
// Depends on rtl/dfd_pkg.sv and rtl/digitizer_frame_decoder_top.sv.
module tb_top;
  import dfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_FILLER, PH_DATA} phase_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  ch;
    logic [15:0] idx;
    logic [15:0] val;
    logic [63:0] ts;
    logic [31:0] cnt;
    logic [63:0] hits;
    logic [31:0] user;
    logic        eor;
  } record_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [31:0]            in_fifo_word = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_record_kind;
  logic [5:0]             out_channel;
  logic [15:0]            out_sample_index;
  logic [15:0]            out_sample_value;
  logic [63:0]            out_frame_timestamp;
  logic [31:0]            out_event_counter;
  logic [63:0]            out_hit_count;
  logic [31:0]            out_user_word;
  logic                   out_end_of_run;

  digitizer_frame_decoder_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_fifo_word        (in_fifo_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_record_kind     (out_record_kind),
    .out_channel         (out_channel),
    .out_sample_index    (out_sample_index),
    .out_sample_value    (out_sample_value),
    .out_frame_timestamp (out_frame_timestamp),
    .out_event_counter   (out_event_counter),
    .out_hit_count       (out_hit_count),
    .out_user_word       (out_user_word),
    .out_end_of_run      (out_end_of_run)
  );

  always #10 clk = ~clk;

  logic [31:0] word_queue[$];
  record_t     awaited_records[$];
  record_t     word_recs[$];
  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned words_taken = 0;
  int unsigned samples_seen = 0;
  int unsigned summaries_seen = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;

  // decoder prediction state
  logic [2:0]  m_chan_log2;
  logic [2:0]  m_en_log2;
  logic [16:0] m_acq_len;
  phase_t      m_phase;
  logic [21:0] m_word_pos;
  logic [4:0]  m_filler_left;
  logic [4:0]  m_pair_pos;
  logic [16:0] m_sample_pos;
  logic [63:0] m_ts;
  logic [31:0] m_cnt;
  logic [63:0] m_hits;
  logic [31:0] m_user;

  function automatic void reset_model();
    m_chan_log2 = 3'd0;
    m_en_log2 = 3'd0;
    m_acq_len = ACQ_LEN_RESET;
    m_phase = PH_HUNT;
    m_word_pos = '0;
    m_filler_left = '0;
    m_pair_pos = '0;
    m_sample_pos = '0;
    m_ts = '0;
    m_cnt = '0;
    m_hits = '0;
    m_user = '0;
  endfunction

  function automatic void apply_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_CHAN_LOG2:    m_chan_log2 = val[2:0];
      CFG_ENABLED_LOG2: m_en_log2 = val[2:0];
      CFG_ACQ_LENGTH:   m_acq_len = val;
      default: ;
    endcase
  endfunction

  function automatic int unsigned eff_chan_log2();
    return (m_chan_log2 > 3'd6) ? 6 : m_chan_log2;
  endfunction

  function automatic int unsigned enabled_count();
    int unsigned e;
    e = (m_en_log2 > eff_chan_log2()) ? eff_chan_log2() : m_en_log2;
    return 1 << e;
  endfunction

  function automatic int unsigned header_len();
    case (eff_chan_log2())
      0, 1:    return 7;
      2, 3, 4: return 8;
      5:       return 16;
      default: return 32;
    endcase
  endfunction

  function automatic int unsigned frame_words();
    int unsigned len;
    int unsigned e;
    len = (m_acq_len > 17'd65536) ? 65536 : m_acq_len;
    e = enabled_count();
    return (e == 1) ? len / 2 : len * (e / 2);
  endfunction

  function automatic void add_record(record_t r);
    word_recs = {word_recs, r};
  endfunction

  function automatic void enqueue_word(logic [31:0] w);
    word_queue = {word_queue, w};
  endfunction

  function automatic void push_sample(logic [5:0] ch, logic [15:0] idx, logic [15:0] val);
    record_t r;
    r = '0;
    r.kind = REC_SAMPLE;
    r.ch = ch;
    r.idx = idx;
    r.val = val;
    add_record(r);
  endfunction

  function automatic void end_frame();
    record_t r;
    r = '0;
    r.kind = REC_SUMMARY;
    r.ts = m_ts;
    r.cnt = m_cnt;
    r.hits = m_hits;
    r.user = m_user;
    add_record(r);
    m_phase = PH_HUNT;
    m_word_pos = '0;
    m_pair_pos = '0;
    m_sample_pos = '0;
    m_filler_left = '0;
  endfunction

  function automatic void start_data();
    m_phase = PH_DATA;
    m_word_pos = '0;
    m_pair_pos = '0;
    m_sample_pos = '0;
    if (frame_words() == 0) end_frame();
  endfunction

  function automatic void decode_word(logic [31:0] w);
    int unsigned e;
    logic [4:0]  p;
    logic [16:0] nxt;
    word_recs.delete();
    case (m_phase)
      PH_HUNT: begin
        if (w == SYNC_WORD) begin
          m_phase = PH_HEADER;
          m_word_pos = 22'd1;
        end
      end
      PH_HEADER: begin
        case (m_word_pos)
          22'd1: m_ts = {32'h0, w};
          22'd2: m_ts[63:32] = w;
          22'd3: m_cnt = w;
          22'd4: m_hits = {32'h0, w};
          22'd5: m_hits[63:32] = w;
          default: m_user = w;
        endcase
        if (m_word_pos >= LAST_HDR_WORD) begin
          m_filler_left = 5'(header_len() - 7);
          if (m_filler_left != 0) m_phase = PH_FILLER;
          else start_data();
        end else begin
          m_word_pos = m_word_pos + 22'd1;
        end
      end
      PH_FILLER: begin
        if (m_filler_left > 0) m_filler_left = m_filler_left - 5'd1;
        if (m_filler_left == 0) start_data();
      end
      default: begin
        e = enabled_count();
        if (e == 1) begin
          nxt = m_sample_pos + 17'd1;
          push_sample(6'd0, m_sample_pos[15:0], w[15:0]);
          push_sample(6'd0, nxt[15:0], w[31:16]);
          m_sample_pos = m_sample_pos + 17'd2;
        end else begin
          p = m_pair_pos;
          push_sample({p, 1'b0}, m_sample_pos[15:0], w[15:0]);
          push_sample({p, 1'b1}, m_sample_pos[15:0], w[31:16]);
          if (int'(p) + 1 >= e / 2) begin
            m_pair_pos = '0;
            m_sample_pos = m_sample_pos + 17'd1;
          end else begin
            m_pair_pos = p + 5'd1;
          end
        end
        m_word_pos = m_word_pos + 22'd1;
        if (m_word_pos >= frame_words()) end_frame();
      end
    endcase
    if (word_recs.size() != 0) word_recs[word_recs.size() - 1].eor = 1'b1;
    foreach (word_recs[i]) awaited_records = {awaited_records, word_recs[i]};
  endfunction

  // input side: beats feed the prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_word(in_fifo_word);
        words_taken++;
      end
      if (cfg_we) apply_cfg(cfg_index, cfg_data);
      if (!in_valid || in_ready) begin
        if (word_queue.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
          in_valid <= 1'b1;
          in_fifo_word <= word_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void report_mismatch(string what, record_t want, record_t got);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      $display("[%0t] %s", $realtime, what);
      $display("  exp kind=%0d ch=%0d idx=%0d val=%h ts=%h cnt=%h hits=%h user=%h eor=%0d",
               want.kind, want.ch, want.idx, want.val, want.ts, want.cnt, want.hits,
               want.user, want.eor);
      $display("  got kind=%0d ch=%0d idx=%0d val=%h ts=%h cnt=%h hits=%h user=%h eor=%0d",
               got.kind, got.ch, got.idx, got.val, got.ts, got.cnt, got.hits,
               got.user, got.eor);
    end
  endfunction

  function automatic void check_record();
    record_t got;
    record_t want;
    got.kind = out_record_kind;
    got.ch = out_channel;
    got.idx = out_sample_index;
    got.val = out_sample_value;
    got.ts = out_frame_timestamp;
    got.cnt = out_event_counter;
    got.hits = out_hit_count;
    got.user = out_user_word;
    got.eor = out_end_of_run;
    if (got.kind === REC_SUMMARY) summaries_seen++;
    else samples_seen++;
    if (awaited_records.size() == 0) begin
      report_mismatch("record with none pending", '0, got);
    end else begin
      want = awaited_records.pop_front();
      if (got !== want) report_mismatch("record mismatch", want, got);
    end
  endfunction

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_record();
      out_ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d records pending", cycle_count,
               awaited_records.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // upper bits of the narrow registers are don't-care, so randomize them
  task automatic set_config(int unsigned chan, int unsigned en, int unsigned len);
    write_cfg(CFG_CHAN_LOG2, {14'($urandom), 3'(chan)});
    write_cfg(CFG_ENABLED_LOG2, {14'($urandom), 3'(en)});
    write_cfg(CFG_ACQ_LENGTH, 17'(len));
    settings_used++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (word_queue.size() != 0 || in_valid || awaited_records.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(15))
      0: return 32'h0;
      1: return SYNC_WORD;
      2: return 32'h0000_FFFF;
      3: return 32'hFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_noise(int unsigned n);
    logic [31:0] w;
    repeat (n) begin
      w = $urandom;
      if (w == SYNC_WORD) w = 32'h0;
      enqueue_word(w);
    end
  endfunction

  function automatic void push_header(logic [63:0] ts, logic [31:0] cnt, logic [63:0] hits,
                                      logic [31:0] user);
    enqueue_word(SYNC_WORD);
    enqueue_word(ts[31:0]);
    enqueue_word(ts[63:32]);
    enqueue_word(cnt);
    enqueue_word(hits[31:0]);
    enqueue_word(hits[63:32]);
    enqueue_word(user);
    repeat (header_len() - 7) enqueue_word(rand_word());
  endfunction

  function automatic void push_frame(logic [63:0] ts, logic [31:0] cnt, logic [63:0] hits,
                                     logic [31:0] user);
    push_header(ts, cnt, hits, user);
    repeat (frame_words()) enqueue_word(rand_word());
  endfunction

  function automatic void push_random_frame();
    push_frame({rand_word(), rand_word()}, rand_word(), {rand_word(), rand_word()},
               rand_word());
  endfunction

  initial begin
    int unsigned chan;
    int unsigned en;
    int unsigned ec;
    int unsigned len;
    int unsigned start;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: one channel, noise before sync, extreme header, sync word as data
    set_config(0, 0, 2);
    push_noise(1);
    enqueue_word(32'hFFFF_FFFE);
    push_frame(64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 64'h8000_0000_0000_0001, 32'hFFFF_FFFF);
    word_queue[word_queue.size() - 1] = SYNC_WORD;
    wait_idle();
    // odd length rounds down
    write_cfg(CFG_ACQ_LENGTH, 17'd3);
    push_frame(64'h0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    wait_idle();
    // no data words: summary on last header word
    write_cfg(CFG_ACQ_LENGTH, 17'd1);
    push_random_frame();
    wait_idle();
    // no data words after filler
    set_config(5, 3, 0);
    push_random_frame();
    wait_idle();
    set_config(2, 2, 2);
    push_random_frame();
    wait_idle();
    // oversized channel settings clamp to 64 channels
    set_config(7, 7, 2);
    push_random_frame();
    wait_idle();
    // more enabled than built
    set_config(1, 5, 5);
    push_random_frame();
    wait_idle();
    // length shrunk mid-frame: frame ends on the next data word
    set_config(0, 0, 8);
    push_header(64'h0123_4567_89AB_CDEF, 32'h5A5A_A5A5, 64'h1, 32'h8000_0000);
    enqueue_word(rand_word());
    enqueue_word(rand_word());
    wait_idle();
    write_cfg(CFG_ACQ_LENGTH, 17'd4);
    enqueue_word(rand_word());
    wait_idle();

    // random phases, each under one setting
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 2);
      if (ph == 0) begin
        chan = 0;
        en = 0;
      end else if (ph == 7) begin
        chan = 7;
        en = 7;
      end else begin
        chan = $urandom_range(7);
        en = $urandom_range(7);
      end
      ec = (en > ((chan > 6) ? 6 : chan)) ? ((chan > 6) ? 6 : chan) : en;
      if (ec <= 1) len = $urandom_range(40);
      else if (ec <= 3) len = $urandom_range(6);
      else len = $urandom_range(2);
      set_config(chan, en, len);
      start = word_queue.size();
      while (word_queue.size() - start < 20) begin
        if ($urandom_range(9) < 3) push_noise($urandom_range(1, 3));
        push_random_frame();
      end
      wait_idle();
    end
    calm = 1'b0;

    // length above the maximum clamps to 65536 samples; shortened to close the frame
    set_config(0, 0, 17'h1FFFF);
    push_header({rand_word(), rand_word()}, rand_word(), {rand_word(), rand_word()},
                rand_word());
    repeat (3) enqueue_word(rand_word());
    wait_idle();
    write_cfg(CFG_ACQ_LENGTH, 17'd2);
    enqueue_word(rand_word());
    wait_idle();

    $display("Run covered %0d words under %0d register settings,", words_taken, settings_used);
    $display("checking %0d sample and %0d frame summary records.", samples_seen,
             summaries_seen);
    if (mismatches == 0 && awaited_records.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d records never seen", mismatches, awaited_records.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
